// ----- rtl/core/brq_pkg.sv -----
// ----------------------------------------------------------------------------
// brq_pkg
// Shared types, widths and index arithmetic for the byte ring queue.
// ----------------------------------------------------------------------------
package brq_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = 7;
  localparam int DATA_W  = 8;
  localparam int ACT_W   = 2;
  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;
  localparam int SUM_W   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_POP    = 2'd1,
    ACT_DROP   = 2'd2,
    ACT_PEEK   = 2'd3
  } action_t;

  // register index taken from paddr above the byte offset
  localparam logic REG_CAPACITY = 1'b0;

  // (idx + step) mod cap, valid while idx < cap and step <= cap
  function automatic logic [IDX_W-1:0] wrap_add(
    input logic [IDX_W-1:0] idx,
    input logic [CNT_W-1:0] step,
    input logic [CNT_W-1:0] cap
  );
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(idx) + SUM_W'(step);
    if (sum >= SUM_W'(cap)) begin
      sum = sum - SUM_W'(cap);
    end
    return sum[IDX_W-1:0];
  endfunction

  // zero reads as one, anything above the built-in depth as the depth
  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] raw);
    logic [CNT_W-1:0] c;
    c = raw;
    if (raw == '0) begin
      c = CNT_W'(1);
    end else if (int'(raw) > DEPTH) begin
      c = CNT_W'(DEPTH);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/byte_ring_queue_with_peek.sv -----
// ----------------------------------------------------------------------------
// byte_ring_queue_with_peek
// Byte ring queue with append, pop, drop and peek; capacity set over APB.
// ----------------------------------------------------------------------------
// Each word passes through S_IDLE and S_READ: the accept cycle updates head,
// tail and count and issues the slot memory access, and S_READ then picks up
// the registered read data into the result register. A new word is taken
// only in S_IDLE, so the next word waits until the last has left S_READ. A
// result waiting on result_ready still lets the next word in, but that word
// then holds in the read cycle and the input stalls until the waiting result
// is taken. Slot contents need no clearing after reset. Writing capacity
// clears head, tail and count while keeping the stored bytes.
module byte_ring_queue_with_peek (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [brq_pkg::ADDR_W-1:0]   paddr,
  input  logic [brq_pkg::PDATA_W-1:0]  pwdata,
  output logic [brq_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic [brq_pkg::ACT_W-1:0]    action,
  input  logic [brq_pkg::DATA_W-1:0]   data_in,
  input  logic [brq_pkg::CNT_W-1:0]    amount,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic                         ok,
  output logic [brq_pkg::DATA_W-1:0]   data_out,
  output logic [brq_pkg::CNT_W-1:0]    count,
  output logic                         empty_res
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t                      state;
  logic [brq_pkg::CNT_W-1:0]   cap_raw;
  logic [brq_pkg::CNT_W-1:0]   cap;
  logic [brq_pkg::IDX_W-1:0]   head;
  logic [brq_pkg::IDX_W-1:0]   tail;
  logic [brq_pkg::CNT_W-1:0]   fill;

  logic [brq_pkg::IDX_W-1:0]   head_next;
  logic [brq_pkg::IDX_W-1:0]   tail_next;
  logic [brq_pkg::CNT_W-1:0]   fill_next;
  logic                        ok_next;
  logic                        need_next;

  logic                        pend_ok;
  logic                        pend_need;
  logic [brq_pkg::CNT_W-1:0]   pend_fill;

  brq_pkg::action_t            act;
  logic                        accept;
  logic                        cfg_wr;
  logic [brq_pkg::CNT_W-1:0]   step;
  logic [brq_pkg::IDX_W-1:0]   head_adv;
  logic [brq_pkg::IDX_W-1:0]   tail_adv;
  logic                        wr_en;
  logic                        rd_en;
  logic [brq_pkg::DATA_W-1:0]  rd_data;
  logic                        load_out;

  assign pready     = 1'b1;
  assign prdata     = brq_pkg::PDATA_W'(cap_raw);
  assign cfg_wr     = psel & penable & pwrite & pready
                      & (paddr[2] == brq_pkg::REG_CAPACITY);
  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid & item_ready;
  assign act        = brq_pkg::action_t'(action);
  assign load_out   = (state == S_READ) & (~result_valid | result_ready);

  assign step     = (act == brq_pkg::ACT_DROP || act == brq_pkg::ACT_PEEK)
                    ? amount : brq_pkg::CNT_W'(1);
  assign head_adv = brq_pkg::wrap_add(head, step, cap);
  assign tail_adv = brq_pkg::wrap_add(tail, brq_pkg::CNT_W'(1), cap);

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    ok_next   = 1'b0;
    need_next = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    case (act)
      brq_pkg::ACT_APPEND: begin
        wr_en     = accept;
        tail_next = tail_adv;
        if (fill < cap) begin
          fill_next = fill + brq_pkg::CNT_W'(1);
        end else begin
          head_next = head_adv;
        end
        ok_next = 1'b1;
      end
      brq_pkg::ACT_POP: begin
        if (fill != '0) begin
          rd_en     = accept;
          need_next = 1'b1;
          head_next = head_adv;
          fill_next = fill - brq_pkg::CNT_W'(1);
          ok_next   = 1'b1;
        end
      end
      brq_pkg::ACT_DROP: begin
        if (amount <= fill) begin
          fill_next = fill - amount;
          head_next = head_adv;
          ok_next   = 1'b1;
        end
      end
      brq_pkg::ACT_PEEK: begin
        if (amount < fill) begin
          rd_en     = accept;
          need_next = 1'b1;
          ok_next   = 1'b1;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  brq_slot_ram u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (data_in),
    .rd_en   (rd_en),
    .rd_addr ((act == brq_pkg::ACT_PEEK) ? head_adv : head),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cap_raw      <= brq_pkg::CAP_RESET;
      cap          <= brq_pkg::clamp_cap(brq_pkg::CAP_RESET);
      head         <= '0;
      tail         <= '0;
      fill         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        cap_raw <= pwdata[brq_pkg::CNT_W-1:0];
        cap     <= brq_pkg::clamp_cap(pwdata[brq_pkg::CNT_W-1:0]);
        head    <= '0;
        tail    <= '0;
        fill    <= '0;
      end else if (accept) begin
        head <= head_next;
        tail <= tail_next;
        fill <= fill_next;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_ok   <= ok_next;
      pend_need <= need_next;
      pend_fill <= fill_next;
    end
    if (load_out) begin
      ok        <= pend_ok;
      data_out  <= pend_need ? rd_data : '0;
      count     <= pend_fill;
      empty_res <= (pend_fill == '0);
    end
  end

endmodule

// ----- rtl/core/brq_slot_ram.sv -----
// ----------------------------------------------------------------------------
// brq_slot_ram
// Byte slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brq_slot_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [brq_pkg::IDX_W-1:0]  wr_addr,
  input  logic [brq_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [brq_pkg::IDX_W-1:0]  rd_addr,
  output logic [brq_pkg::DATA_W-1:0] rd_data
);

  logic [brq_pkg::DATA_W-1:0] mem [brq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
